// ----- sv/i2cbe_pkg.sv -----
// Shared definitions for the I2C master bit engine.
// Command codes, field widths and the shifter control bundle.
// No dependencies.
package i2cbe_pkg;

    // Data bits in one byte transfer
    localparam int BITS_PER_BYTE_DEF = 8;

    // Width of the hold time register
    localparam int HOLD_W = 10;
    localparam logic [HOLD_W-1:0] HOLD_RESET = 10'd7;

    // Command codes
    localparam int CMD_W = 3;
    localparam logic [CMD_W-1:0] CMD_START = 3'd0;
    localparam logic [CMD_W-1:0] CMD_STOP  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SACK  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_RACK  = 3'd5;

    // Control bundle from the sequencer to the bit shifter
    typedef struct packed {
        logic load;      // load transmit byte, clear receive byte
        logic shift_tx;  // advance transmit byte by one bit
        logic shift_rx;  // take one bit into the receive byte
    } t_shift_ctrl;

endpackage

// ----- sv/i2c_master_bit_engine.sv -----
// Top level of the I2C master bit engine: command sequencer, pin state,
// result register and hold time register.
// Depends on i2cbe_pkg, i2cbe_shifter and i2cbe_hold_timer.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | i_in_valid/o_in_ready, command and fields | request in
//  out     | o_out_valid/i_out_ready, pin levels etc.  | result out
//  cfg     | i_cfg_valid/o_cfg_ready, i_cfg_data       | hold_ticks write
//
// One command request at a time. Each pin write is formed in ST_STEP, waits
// in the result register until taken, then holds in the hold timer for the
// hold_ticks window. A command makes 4, 3, 24, 17 or 3 pin writes (start,
// stop, write, read, either ack). Commands 6 and 7 are accepted but give no
// result. Reset releases both lines and loads hold_ticks with 7.
// A stalled output freezes the sequencer; the cfg port is always ready.
module i2c_master_bit_engine
    import i2cbe_pkg::*;
#(
    parameter int BITS_PER_BYTE = BITS_PER_BYTE_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // command requests
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [CMD_W-1:0]         i_command,
    input  logic [BITS_PER_BYTE-1:0] i_write_data,
    input  logic                     i_ack_out,
    input  logic [BITS_PER_BYTE-1:0] i_bus_bits,
    input  logic                     i_bus_ack,
    // results
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic                     o_scl_level,
    output logic                     o_sda_level,
    output logic [BITS_PER_BYTE-1:0] o_read_data,
    output logic                     o_ack_in,
    output logic                     o_last,
    // hold time register
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [HOLD_W-1:0]        i_cfg_data
);

    localparam int BIT_W = $clog2(BITS_PER_BYTE);
    localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(BITS_PER_BYTE - 1);

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_STEP = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;
    localparam logic [1:0] ST_HOLD = 2'd3;

    // Pin write slots within a command
    localparam logic [1:0] PH_A = 2'd0;
    localparam logic [1:0] PH_B = 2'd1;
    localparam logic [1:0] PH_C = 2'd2;
    localparam logic [1:0] PH_D = 2'd3;

    logic [1:0]               r_state, n_state;
    logic [1:0]               r_phase, n_phase;
    logic [BIT_W-1:0]         r_bit, n_bit;
    logic [CMD_W-1:0]         r_cmd;
    logic                     r_ack_out;
    logic                     r_bus_ack;
    logic [HOLD_W-1:0]        r_hold_ticks;
    logic                     r_scl, n_scl;
    logic                     r_sda, n_sda;
    logic [BITS_PER_BYTE-1:0] r_rd, n_rd;
    logic                     r_ack, n_ack;
    logic                     r_last, n_last;

    logic                     in_acc;
    logic                     out_acc;
    logic                     cmd_known;
    logic                     tx_msb;
    logic [BITS_PER_BYTE-1:0] rx_data;
    logic                     hold_expire;
    t_shift_ctrl              shift_ctrl;

    assign in_acc    = i_in_valid && o_in_ready;
    assign out_acc   = o_out_valid && i_out_ready;
    assign cmd_known = i_command inside {[CMD_START:CMD_RACK]};

    // Decode the current pin write and step the slot counters
    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_bit    = r_bit;
        n_scl    = r_scl;
        n_sda    = r_sda;
        n_rd     = r_rd;
        n_ack    = r_ack;
        n_last   = r_last;
        shift_ctrl = '0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && cmd_known) begin
                    shift_ctrl.load = 1'b1;
                    n_phase = PH_A;
                    n_bit   = '0;
                    n_state = ST_STEP;
                end
            end
            ST_STEP: begin
                n_rd    = '0;
                n_ack   = 1'b0;
                n_last  = 1'b0;
                n_phase = r_phase + 2'd1;
                n_state = ST_EMIT;
                case (r_cmd)
                    CMD_START: begin
                        case (r_phase)
                            PH_A: n_sda = 1'b1;
                            PH_B: n_scl = 1'b1;
                            PH_C: n_sda = 1'b0;
                            PH_D: begin
                                n_scl  = 1'b0;
                                n_last = 1'b1;
                            end
                            default: n_last = 1'b1;
                        endcase
                    end
                    CMD_STOP: begin
                        case (r_phase)
                            PH_A: n_sda = 1'b0;
                            PH_B: n_scl = 1'b1;
                            default: begin
                                n_sda  = 1'b1;
                                n_last = 1'b1;
                            end
                        endcase
                    end
                    CMD_WRITE: begin
                        case (r_phase)
                            PH_A: n_sda = tx_msb;
                            PH_B: n_scl = 1'b1;
                            default: begin
                                n_scl = 1'b0;
                                shift_ctrl.shift_tx = 1'b1;
                                n_phase = PH_A;
                                n_bit   = r_bit + BIT_W'(1);
                                n_last  = (r_bit == BIT_LAST);
                            end
                        endcase
                    end
                    CMD_READ: begin
                        case (r_phase)
                            PH_A: n_sda = 1'b1;
                            PH_B: begin
                                // sample the bus bit while SCL is high
                                n_scl = 1'b1;
                                shift_ctrl.shift_tx = 1'b1;
                                shift_ctrl.shift_rx = 1'b1;
                            end
                            default: begin
                                n_scl   = 1'b0;
                                n_phase = PH_B;
                                n_bit   = r_bit + BIT_W'(1);
                                n_last  = (r_bit == BIT_LAST);
                                n_rd    = (r_bit == BIT_LAST) ? rx_data : '0;
                            end
                        endcase
                    end
                    CMD_SACK, CMD_RACK: begin
                        case (r_phase)
                            PH_A: n_sda = (r_cmd == CMD_SACK) ? r_ack_out : 1'b1;
                            PH_B: n_scl = 1'b1;
                            default: begin
                                n_scl  = 1'b0;
                                n_last = 1'b1;
                                n_ack  = (r_cmd == CMD_RACK) ? r_bus_ack : 1'b0;
                            end
                        endcase
                    end
                    default: n_state = ST_IDLE;
                endcase
            end
            ST_EMIT: begin
                if (out_acc) begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (hold_expire) begin
                    n_state = r_last ? ST_IDLE : ST_STEP;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control state and pin levels
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_phase      <= PH_A;
            r_bit        <= '0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_last       <= 1'b0;
            r_hold_ticks <= HOLD_RESET;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_bit   <= n_bit;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_last  <= n_last;
            if (i_cfg_valid && o_cfg_ready) begin
                r_hold_ticks <= i_cfg_data;
            end
        end
    end

    // Latch the request fields and the result payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd     <= i_command;
            r_ack_out <= i_ack_out;
            r_bus_ack <= i_bus_ack;
        end
        r_rd  <= n_rd;
        r_ack <= n_ack;
    end

    i2cbe_shifter #(
        .BITS_PER_BYTE(BITS_PER_BYTE)
    ) u_shifter (
        .i_clk      (i_clk),
        .i_ctrl     (shift_ctrl),
        .i_load_data((i_command == CMD_READ) ? i_bus_bits : i_write_data),
        .i_rx_bit   (tx_msb),
        .o_tx_msb   (tx_msb),
        .o_rx_data  (rx_data)
    );

    i2cbe_hold_timer u_hold_timer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (out_acc),
        .i_ticks (r_hold_ticks),
        .o_expire(hold_expire)
    );

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_EMIT);
    assign o_cfg_ready = 1'b1;
    assign o_scl_level = r_scl;
    assign o_sda_level = r_sda;
    assign o_read_data = r_rd;
    assign o_ack_in    = r_ack;
    assign o_last      = r_last;

    // A taken result always starts a hold window
    a_hold_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |=> (r_state == ST_HOLD))
        else $error("result taken without hold window");

    // A known command always starts forming a pin write
    a_step_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && cmd_known) |=> (r_state == ST_STEP))
        else $error("accepted command did not start");

    // Read data only on the final write of a read command
    a_rd_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_read_data != '0)) |-> (o_last && r_cmd == CMD_READ))
        else $error("read data outside last read result");

    // Ack bit only on the final write of receive ack
    a_ack_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_ack_in) |-> (o_last && r_cmd == CMD_RACK))
        else $error("ack outside last receive ack result");

    // Pins move only while a write is being formed
    a_pins_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) != ST_STEP && $past(i_rst_n)) |->
            ($stable(r_scl) && $stable(r_sda)))
        else $error("pin level changed outside a write");

endmodule

// ----- sv/i2cbe_shifter.sv -----
// Bit shifter of the I2C master bit engine: one transmit and one receive
// register, each moved by one bit per request from the sequencer.
// Depends on i2cbe_pkg.
module i2cbe_shifter
    import i2cbe_pkg::*;
#(
    parameter int BITS_PER_BYTE = BITS_PER_BYTE_DEF
) (
    input  logic                     i_clk,
    input  t_shift_ctrl              i_ctrl,
    input  logic [BITS_PER_BYTE-1:0] i_load_data,
    input  logic                     i_rx_bit,
    output logic                     o_tx_msb,
    output logic [BITS_PER_BYTE-1:0] o_rx_data
);

    logic [BITS_PER_BYTE-1:0] r_tx;
    logic [BITS_PER_BYTE-1:0] r_rx;

    // Load on a new command, then shift MSB first
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_tx <= i_load_data;
            r_rx <= '0;
        end else begin
            if (i_ctrl.shift_tx) begin
                r_tx <= {r_tx[BITS_PER_BYTE-2:0], 1'b0};
            end
            if (i_ctrl.shift_rx) begin
                r_rx <= {r_rx[BITS_PER_BYTE-2:0], i_rx_bit};
            end
        end
    end

    assign o_tx_msb  = r_tx[BITS_PER_BYTE-1];
    assign o_rx_data = r_rx;

endmodule

// ----- sv/i2cbe_hold_timer.sv -----
// Hold timer of the I2C master bit engine: counts down the hold time
// that follows every pin write.
// Depends on i2cbe_pkg.
module i2cbe_hold_timer
    import i2cbe_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic [HOLD_W-1:0] i_ticks,
    output logic              o_expire
);

    logic [HOLD_W-1:0] r_count;
    logic [HOLD_W-1:0] n_count;

    // Load on request, otherwise count down and stop at zero
    always_comb begin
        n_count = r_count;
        if (i_load) begin
            n_count = i_ticks;
        end else if (r_count != '0) begin
            n_count = r_count - HOLD_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Last cycle of the hold window
    assign o_expire = (r_count <= HOLD_W'(1));

endmodule
